// File: src/bpc_pkg.sv
// bpc_pkg: shared types and constants for the button press classifier.
// Used by bpc_core and button_press_classifier; depends on nothing.

package bpc_pkg;

  // Press timer width; thresholds stay 16 bits and are zero-extended as needed.
  localparam int unsigned TimerBits = 16;
  localparam int unsigned RegBits   = 16;
  localparam int unsigned CmpBits   = (TimerBits > RegBits) ? TimerBits : RegBits;
  localparam int unsigned EventBits = 3;
  localparam int unsigned CfgIdxBits = 3;

  // Event codes
  localparam logic [EventBits-1:0] EvNone   = 3'd0;
  localparam logic [EventBits-1:0] EvClick  = 3'd1;
  localparam logic [EventBits-1:0] EvLong3  = 3'd2;
  localparam logic [EventBits-1:0] EvLong4  = 3'd3;
  localparam logic [EventBits-1:0] EvLong5  = 3'd4;
  localparam logic [EventBits-1:0] EvLong6  = 3'd5;
  localparam logic [EventBits-1:0] EvDouble = 3'd6;

  // Register indexes on the config channel
  localparam logic [CfgIdxBits-1:0] RegDebounce   = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegDoubleGap  = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegShortLimit = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegLong3      = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegLong4      = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegLong5      = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegLong6      = 3'd6;

  // Register reset values
  localparam logic [RegBits-1:0] DebounceRst   = 16'd20;
  localparam logic [RegBits-1:0] DoubleGapRst  = 16'd300;
  localparam logic [RegBits-1:0] ShortLimitRst = 16'd2000;
  localparam logic [RegBits-1:0] Long3Rst      = 16'd3000;
  localparam logic [RegBits-1:0] Long4Rst      = 16'd4000;
  localparam logic [RegBits-1:0] Long5Rst      = 16'd5000;
  localparam logic [RegBits-1:0] Long6Rst      = 16'd6000;

  typedef struct packed {
    logic [RegBits-1:0] debounce;
    logic [RegBits-1:0] double_gap;
    logic [RegBits-1:0] short_limit;
    logic [RegBits-1:0] long3;
    logic [RegBits-1:0] long4;
    logic [RegBits-1:0] long5;
    logic [RegBits-1:0] long6;
  } cfg_t;

endpackage

// File: src/button_press_classifier.sv
// button_press_classifier: key tick stream in, click / long / double events out.
// Depends on bpc_pkg and bpc_core.
//
// Channel   Dir  Handshake                      Content
// s_axis    in   s_axis_tvalid/s_axis_tready    one sampled key level per transfer
// m_axis    out  m_axis_tvalid/m_axis_tready    one event code per input transfer
// cfg       in   cfg_valid_i/cfg_ready_o        register index + 16-bit value
//
// Each tick passes the input register, then the result register, and a new tick
// is taken every cycle while m_axis is not stalled; bpc_core updates its phase
// and timer once per tick.
// Reset (rst_ni low, async) empties both stages, returns to idle with a zero
// timer and reloads the register defaults.
// A stalled result holds; the input stage still takes one more transfer.
// Config is always ready; write only while the block is idle.

module button_press_classifier
  import bpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [0] pressed, [7:1] zero
  // event stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [2:0] event_res, [7:3] zero
  // config writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [RegBits-1:0]    cfg_data_i
);

  logic                 in_vld_q, in_vld_d;
  logic                 in_prs_q;
  logic                 out_vld_q, out_vld_d;
  logic [EventBits-1:0] out_ev_q;
  logic [EventBits-1:0] ev;
  logic                 step;
  logic                 s_xfer;
  cfg_t                 cfg_q, cfg_d;

  // Advance the held tick into the result register when it has room.
  assign step          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || step;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  assign in_vld_d  = s_xfer ? 1'b1 : (step ? 1'b0 : in_vld_q);
  assign out_vld_d = step ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);

  bpc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .pressed_i (in_prs_q),
    .cfg_i     (cfg_q),
    .event_o   (ev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload stages, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_prs_q <= s_axis_tdata[0];
    end
    if (step) begin
      out_ev_q <= ev;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(8-EventBits){1'b0}}, out_ev_q};

  // Config registers; index 7 is dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDebounce:   cfg_d.debounce    = cfg_data_i;
        RegDoubleGap:  cfg_d.double_gap  = cfg_data_i;
        RegShortLimit: cfg_d.short_limit = cfg_data_i;
        RegLong3:      cfg_d.long3       = cfg_data_i;
        RegLong4:      cfg_d.long4       = cfg_data_i;
        RegLong5:      cfg_d.long5       = cfg_data_i;
        RegLong6:      cfg_d.long6       = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce    <= DebounceRst;
      cfg_q.double_gap  <= DoubleGapRst;
      cfg_q.short_limit <= ShortLimitRst;
      cfg_q.long3       <= Long3Rst;
      cfg_q.long4       <= Long4Rst;
      cfg_q.long5       <= Long5Rst;
      cfg_q.long6       <= Long6Rst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: src/bpc_core.sv
// bpc_core: phase register, saturating press timer and event decode.
// Depends on bpc_pkg.

module bpc_core
  import bpc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,     // advance state by one tick
  input  logic                 pressed_i,
  input  cfg_t                 cfg_i,
  output logic [EventBits-1:0] event_o     // event for this tick
);

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhHeld   = 2'd1;
  localparam logic [1:0] PhAwait  = 2'd2;
  localparam logic [1:0] PhSecond = 2'd3;

  localparam logic [TimerBits-1:0] TimerMax = {TimerBits{1'b1}};

  logic [1:0]           phase_q, phase_d;
  logic [TimerBits-1:0] elapsed_q, elapsed_d;
  logic [TimerBits-1:0] cnt;
  logic [CmpBits-1:0]   cnt_x;

  function automatic logic reached(input logic [CmpBits-1:0] t, input logic [RegBits-1:0] thr);
    reached = (t >= CmpBits'(thr));
  endfunction

  assign cnt   = (elapsed_q == TimerMax) ? elapsed_q : elapsed_q + 1'b1;
  assign cnt_x = CmpBits'(cnt);

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = cnt;
    event_o   = EvNone;
    case (phase_q)
      PhIdle: begin
        elapsed_d = '0;
        if (pressed_i) begin
          phase_d = PhHeld;
        end
      end
      PhHeld: begin
        if (!pressed_i) begin
          phase_d = PhIdle;
          if (!reached(cnt_x, cfg_i.debounce)) begin
            event_o = EvNone;
          end else if (reached(cnt_x, cfg_i.long6)) begin
            event_o = EvLong6;
          end else if (reached(cnt_x, cfg_i.long5)) begin
            event_o = EvLong5;
          end else if (reached(cnt_x, cfg_i.long4)) begin
            event_o = EvLong4;
          end else if (reached(cnt_x, cfg_i.long3)) begin
            event_o = EvLong3;
          end else if (!reached(cnt_x, cfg_i.short_limit)) begin
            phase_d   = PhAwait;   // short click, wait for a second press
            elapsed_d = '0;
          end else if (reached(cnt_x, cfg_i.double_gap)) begin
            event_o = EvClick;
          end
        end
      end
      PhAwait: begin
        if (pressed_i) begin
          phase_d   = PhSecond;
          elapsed_d = '0;
        end else if (reached(cnt_x, cfg_i.double_gap)) begin
          phase_d = PhIdle;
          event_o = EvClick;
        end
      end
      default: begin
        if (!pressed_i) begin
          phase_d = PhIdle;
          event_o = reached(cnt_x, cfg_i.short_limit) ? EvNone : EvDouble;
        end
      end
    endcase
    if (phase_d == PhIdle) begin
      elapsed_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      elapsed_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule
